// File: design/deq_pkg.sv
package deq_pkg;

    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [1:0] {
        KIND_PUSH_BACK  = 2'd0,
        KIND_POP_BACK   = 2'd1,
        KIND_PUSH_FRONT = 2'd2,
        KIND_POP_FRONT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    // what every cell of the ring does on a clock edge
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_POP_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_BACK,
        CELL_ROT_RIGHT,
        CELL_ROT_LEFT
    } t_cell_op;

endpackage

// File: design/deq_req_if.sv
interface deq_req_if import deq_pkg::*; ();
    logic                valid;
    logic                ready;
    t_kind               kind;
    logic [DATA_W-1:0]   data_word;

    modport source (output valid, output kind, output data_word, input ready);
    modport sink   (input valid, input kind, input data_word, output ready);
endinterface

// File: design/deq_rsp_if.sv
interface deq_rsp_if import deq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [DATA_W-1:0]      popped_word;
    t_status                status;
    logic [COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, output popped_word, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input popped_word, input status, input entry_count,
                    output ready);
endinterface

// File: design/deq_cell.sv
module deq_cell import deq_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int WORD_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                              i_clk,
    input  t_cell_op                          i_op,
    input  logic [$clog2(CAPACITY+1)-1:0]     i_front_cnt,
    input  logic [$clog2(CAPACITY+1)-1:0]     i_back_cnt,
    input  logic [WORD_WIDTH-1:0]             i_word,
    input  logic [WORD_WIDTH-1:0]             i_left,
    input  logic [WORD_WIDTH-1:0]             i_right,
    output logic [WORD_WIDTH-1:0]             o_word
);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;

    always_comb begin
        int a;
        int b;
        a = int'(i_front_cnt);
        b = int'(i_back_cnt);
        n_word = r_word;
        case (i_op)
            CELL_PUSH_FRONT: begin
                if (INDEX == 0) begin
                    n_word = i_word;
                end else if (INDEX <= a) begin
                    n_word = i_left;
                end
            end
            CELL_POP_FRONT: begin
                if (INDEX + 1 < a) begin
                    n_word = i_right;
                end
            end
            CELL_PUSH_BACK: begin
                if (INDEX == CAPACITY - 1) begin
                    n_word = i_word;
                end else if (INDEX + 1 + b >= CAPACITY) begin
                    n_word = i_right;
                end
            end
            CELL_POP_BACK: begin
                if (INDEX + b > CAPACITY) begin
                    n_word = i_left;
                end
            end
            CELL_ROT_RIGHT: n_word = i_left;
            CELL_ROT_LEFT:  n_word = i_right;
            default:        n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// File: design/double_ended_queue_core.sv
// double-ended queue of data words held in a ring of cells
//
// i_req (sink): kind and data_word, one request per accept.
// o_rsp (source): popped_word, status and entry_count, exactly one per request,
// in request order.
//
// The ring holds two stacks: the front stack grows right from cell 0 and the
// back stack grows left from the last cell, so both ends are read at fixed
// cells. Pushes, pops on a side that still holds words and requests that end
// in underflow or overflow are answered in the output register the cycle
// after the accept: one request per cycle sustained while results are taken.
// A pop on a side that has run dry while the other side holds n words first
// rotates the ring once per cycle to move all n words across; that request
// passes through the accept, the rotations and then the pop, which waits
// while the receiver stalls and registers the result; no request is taken
// meanwhile.
//
// Reset clears the counts and the result valid; the ring holds nothing.
// While the receiver stalls, the result waits in the output register and new
// requests are held off until it is taken.
module double_ended_queue_core import deq_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    deq_req_if.sink   i_req,
    deq_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE_FRONT,
        S_MOVE_BACK,
        S_DONE
    } t_state;

    t_state                r_state,     n_state;
    t_kind                 r_kind,      n_kind;
    logic [CW-1:0]         r_front,     n_front;
    logic [CW-1:0]         r_back,      n_back;
    logic                  r_rsp_valid, n_rsp_valid;
    logic [WORD_WIDTH-1:0] r_popped,    n_popped;
    t_status               r_status,    n_status;
    logic [CW:0]           r_count,     n_count;

    t_cell_op              cell_op;
    logic [WORD_WIDTH-1:0] w_cell [CAPACITY];
    logic [WORD_WIDTH-1:0] push_word;
    logic [WORD_WIDTH+DATA_W-1:0] in_ext;
    logic [WORD_WIDTH+DATA_W-1:0] out_ext;
    logic [CW+COUNT_OUT_W:0]      cnt_ext;

    logic [CW:0] total;
    logic        full;
    logic        empty;
    logic        slot_free;
    logic        accept;
    logic        need_move;
    logic        exec_fire;
    t_kind       exec_kind;

    assign in_ext    = {{WORD_WIDTH{1'b0}}, i_req.data_word};
    assign push_word = in_ext[WORD_WIDTH-1:0];

    assign total = {1'b0, r_front} + {1'b0, r_back};
    assign full  = (total == (CW+1)'(CAPACITY));
    assign empty = (total == '0);

    assign slot_free   = !r_rsp_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && slot_free;
    assign accept      = i_req.valid && i_req.ready;

    assign need_move = ((i_req.kind == KIND_POP_FRONT) && (r_front == '0) && !empty) ||
                       ((i_req.kind == KIND_POP_BACK)  && (r_back == '0)  && !empty);

    assign exec_fire = (accept && !need_move) || ((r_state == S_DONE) && slot_free);
    assign exec_kind = (r_state == S_DONE) ? r_kind : i_req.kind;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_front     = r_front;
        n_back      = r_back;
        n_rsp_valid = r_rsp_valid;
        n_popped    = r_popped;
        n_status    = r_status;
        n_count     = r_count;
        cell_op     = CELL_HOLD;

        case (r_state)
            S_IDLE: begin
                if (accept && need_move) begin
                    n_kind  = i_req.kind;
                    n_state = (i_req.kind == KIND_POP_FRONT) ? S_MOVE_FRONT : S_MOVE_BACK;
                end
            end
            S_MOVE_FRONT: begin
                cell_op = CELL_ROT_RIGHT;
                n_front = r_front + 1'b1;
                n_back  = r_back - 1'b1;
                if (r_back == CW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_MOVE_BACK: begin
                cell_op = CELL_ROT_LEFT;
                n_front = r_front - 1'b1;
                n_back  = r_back + 1'b1;
                if (r_front == CW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (exec_fire) begin
            n_rsp_valid = 1'b1;
            n_popped    = '0;
            n_status    = ST_OK;
            case (exec_kind)
                KIND_PUSH_BACK: begin
                    if (full) begin
                        n_status = ST_OVER;
                    end else begin
                        cell_op = CELL_PUSH_BACK;
                        n_back  = r_back + 1'b1;
                    end
                end
                KIND_PUSH_FRONT: begin
                    if (full) begin
                        n_status = ST_OVER;
                    end else begin
                        cell_op = CELL_PUSH_FRONT;
                        n_front = r_front + 1'b1;
                    end
                end
                KIND_POP_BACK: begin
                    if (empty) begin
                        n_status = ST_UNDER;
                    end else begin
                        cell_op  = CELL_POP_BACK;
                        n_popped = w_cell[CAPACITY-1];
                        n_back   = r_back - 1'b1;
                    end
                end
                KIND_POP_FRONT: begin
                    if (empty) begin
                        n_status = ST_UNDER;
                    end else begin
                        cell_op  = CELL_POP_FRONT;
                        n_popped = w_cell[0];
                        n_front  = r_front - 1'b1;
                    end
                end
                default: n_status = ST_OK;
            endcase
            n_count = {1'b0, n_front} + {1'b0, n_back};
        end else if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_rsp_valid <= n_rsp_valid;
        end
        r_kind   <= n_kind;
        r_popped <= n_popped;
        r_status <= n_status;
        r_count  <= n_count;
    end

    // ring of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        deq_cell #(
            .CAPACITY   (CAPACITY),
            .WORD_WIDTH (WORD_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (cell_op),
            .i_front_cnt (r_front),
            .i_back_cnt  (r_back),
            .i_word      (push_word),
            .i_left      (w_cell[(g + CAPACITY - 1) % CAPACITY]),
            .i_right     (w_cell[(g + 1) % CAPACITY]),
            .o_word      (w_cell[g])
        );
    end

    assign out_ext = {{DATA_W{1'b0}}, r_popped};
    assign cnt_ext = {{COUNT_OUT_W{1'b0}}, r_count};

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.popped_word = out_ext[DATA_W-1:0];
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = cnt_ext[COUNT_OUT_W-1:0];

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        total <= (CW+1)'(CAPACITY))
        else $error("entry total beyond capacity");

    a_move_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready)
        else $error("request taken while moving words");

    a_move_front_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE_FRONT) |=> (r_front == $past(r_front) + 1'b1))
        else $error("front stack not grown by one during move");

    a_done_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_kind == KIND_POP_FRONT) |-> (r_front != '0 && r_back == '0))
        else $error("front pop after move finds front stack empty");

    a_done_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_kind == KIND_POP_BACK) |-> (r_back != '0 && r_front == '0))
        else $error("back pop after move finds back stack empty");

endmodule

// File: dv/double_ended_queue_core_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
    import deq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int RANDOM_REQS = 450;
    localparam int SETTLE_CYC  = 100;
    localparam int LIST_LEN    = 4096;

    typedef struct packed {
        logic [DATA_W-1:0]      popped_word;
        t_status                status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_answer;

    typedef struct packed {
        t_kind                  kind;
        logic [DATA_W-1:0]      data_word;
        logic                   typed;
        logic [DATA_W-1:0]      popped_word;
        t_status                status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    deq_req_if req_if ();
    deq_rsp_if rsp_if ();

    double_ended_queue_core #(
        .CAPACITY   (DEPTH),
        .WORD_WIDTH (DATA_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // own copy of the deque
    logic [DATA_W-1:0]      ring [DEPTH];
    logic [5:0]             front_ptr;
    logic [COUNT_OUT_W-1:0] fill;

    t_answer want_list [LIST_LEN];
    int      want_wr;
    int      want_rd;
    int      sent_reqs;
    int      answered;
    int      fail_count;
    int      reported;
    bit      sender_calm;

    t_dir_row dir_rows [18] = '{
        '{KIND_POP_BACK,   32'hDEAD_BEEF, 1'b1, 32'h0,         ST_UNDER, 7'd0},
        '{KIND_POP_FRONT,  32'hFFFF_FFFF, 1'b1, 32'h0,         ST_UNDER, 7'd0},
        '{KIND_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, 32'h0,         ST_OK,    7'd1},
        '{KIND_PUSH_FRONT, 32'h0000_0000, 1'b1, 32'h0,         ST_OK,    7'd2},
        '{KIND_PUSH_BACK,  32'hA5A5_A5A5, 1'b1, 32'h0,         ST_OK,    7'd3},
        '{KIND_POP_FRONT,  32'h1234_5678, 1'b1, 32'h0,         ST_OK,    7'd2},
        '{KIND_POP_FRONT,  32'h0,         1'b1, 32'hFFFF_FFFF, ST_OK,    7'd1},
        '{KIND_POP_FRONT,  32'h0,         1'b1, 32'hA5A5_A5A5, ST_OK,    7'd0},
        '{KIND_POP_BACK,   32'h0,         1'b1, 32'h0,         ST_UNDER, 7'd0},
        '{KIND_PUSH_FRONT, 32'h5A5A_5A5A, 1'b1, 32'h0,         ST_OK,    7'd1},
        '{KIND_PUSH_FRONT, 32'h0000_0001, 1'b1, 32'h0,         ST_OK,    7'd2},
        '{KIND_POP_BACK,   32'hFFFF_FFFF, 1'b1, 32'h5A5A_5A5A, ST_OK,    7'd1},
        '{KIND_POP_BACK,   32'h0,         1'b1, 32'h0000_0001, ST_OK,    7'd0},
        '{KIND_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h0,         ST_OK,    7'd1},
        '{KIND_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, 32'h0,         ST_OK,    7'd0},
        '{KIND_POP_FRONT,  32'h0,         1'b0, 32'h0,         ST_OK,    7'd0},
        '{KIND_POP_BACK,   32'h0,         1'b0, 32'h0,         ST_OK,    7'd0},
        '{KIND_POP_FRONT,  32'h0,         1'b0, 32'h0,         ST_OK,    7'd0}
    };

    always #2 i_clk = ~i_clk;

    function automatic t_answer deque_step(t_kind kind, logic [DATA_W-1:0] word);
        t_answer    ans;
        logic [5:0] slot;
        ans.popped_word = '0;
        ans.status      = ST_OK;
        case (kind)
            KIND_PUSH_BACK: begin
                if (fill == DEPTH) begin
                    ans.status = ST_OVER;
                end else begin
                    slot       = front_ptr + fill[5:0];
                    ring[slot] = word;
                    fill       = fill + 1'b1;
                end
            end
            KIND_PUSH_FRONT: begin
                if (fill == DEPTH) begin
                    ans.status = ST_OVER;
                end else begin
                    front_ptr       = front_ptr - 6'd1;
                    ring[front_ptr] = word;
                    fill            = fill + 1'b1;
                end
            end
            KIND_POP_BACK: begin
                if (fill == 0) begin
                    ans.status = ST_UNDER;
                end else begin
                    slot            = front_ptr + fill[5:0] - 6'd1;
                    ans.popped_word = ring[slot];
                    fill            = fill - 1'b1;
                end
            end
            default: begin
                if (fill == 0) begin
                    ans.status = ST_UNDER;
                end else begin
                    ans.popped_word = ring[front_ptr];
                    front_ptr       = front_ptr + 6'd1;
                    fill            = fill - 1'b1;
                end
            end
        endcase
        ans.entry_count = fill;
        return ans;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_req(t_kind kind, logic [DATA_W-1:0] word, bit typed,
                            t_answer typed_ans);
        int      gap;
        t_answer ans;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid     <= 1'b1;
        req_if.kind      <= kind;
        req_if.data_word <= word;
        do @(posedge i_clk); while (!req_if.ready);
        ans = deque_step(kind, word);
        want_list[want_wr] = typed ? typed_ans : ans;
        want_wr++;
        sent_reqs++;
    endtask

    task automatic send_plain(t_kind kind);
        send_req(kind, $urandom, 1'b0, '0);
    endtask

    function automatic t_kind side_kind(int mode, t_kind back_k, t_kind front_k);
        if (mode == 0) return back_k;
        if (mode == 1) return front_k;
        return $urandom_range(0, 1) ? back_k : front_k;
    endfunction

    // stimulus
    initial begin
        int      mode;
        int      n;
        t_answer typed_ans;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.kind      = KIND_PUSH_BACK;
        req_if.data_word = '0;
        front_ptr        = '0;
        fill             = '0;
        sent_reqs        = 0;
        want_wr          = 0;
        sender_calm      = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            typed_ans.popped_word = dir_rows[i].popped_word;
            typed_ans.status      = dir_rows[i].status;
            typed_ans.entry_count = dir_rows[i].entry_count;
            send_req(dir_rows[i].kind, dir_rows[i].data_word, dir_rows[i].typed, typed_ans);
        end

        while (sent_reqs < RANDOM_REQS + 18) begin
            sender_calm = ($urandom_range(0, 4) == 0);
            mode        = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // fill to the brim, then push into a full queue
                    while (fill < DEPTH)
                        send_plain(side_kind(mode, KIND_PUSH_BACK, KIND_PUSH_FRONT));
                    repeat ($urandom_range(1, 3))
                        send_plain(side_kind(2, KIND_PUSH_BACK, KIND_PUSH_FRONT));
                end
                4, 5, 6: begin
                    // drain, often from one end only, then pop the empty queue
                    while (fill > 0)
                        send_plain(side_kind(mode, KIND_POP_BACK, KIND_POP_FRONT));
                    repeat ($urandom_range(1, 2))
                        send_plain(side_kind(2, KIND_POP_BACK, KIND_POP_FRONT));
                end
                7, 8: begin
                    n = $urandom_range(1, 20);
                    repeat (n) send_plain(t_kind'($urandom_range(0, 3)));
                end
                default: begin
                    // pairs of a push at a random end and a pop at a random end
                    n = $urandom_range(2, 12);
                    repeat (n) begin
                        send_plain($urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT);
                        send_plain($urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT);
                    end
                end
            endcase
        end

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (want_rd < want_wr) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // response side
    initial begin
        int      stall_left;
        int      next_hold_at;
        bit      rcv_calm;
        bit      rdy;
        t_answer want;
        t_answer got;
        rsp_if.ready = 1'b0;
        answered     = 0;
        fail_count   = 0;
        reported     = 0;
        want_rd      = 0;
        stall_left   = 0;
        next_hold_at = 120;
        rcv_calm     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (answered >= next_hold_at) begin
                // long hold-off so the block backs up onto its input
                stall_left   = 250;
                next_hold_at = next_hold_at + 210;
            end
            if ($urandom_range(0, 59) == 0) rcv_calm = ~rcv_calm;
            if (stall_left > 0) begin
                rdy        = 1'b0;
                stall_left = stall_left - 1;
            end else begin
                rdy = 1'b1;
                if (!rcv_calm) stall_left = pick_gap(1'b0);
            end
            rsp_if.ready <= rdy;
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                answered++;
                got.popped_word = rsp_if.popped_word;
                got.status      = rsp_if.status;
                got.entry_count = rsp_if.entry_count;
                if (want_rd == want_wr) begin
                    fail_count++;
                    if (reported < 10) begin
                        reported++;
                        $display("unexpected response: word %h status %0d count %0d",
                                 got.popped_word, got.status, got.entry_count);
                    end
                end else begin
                    want = want_list[want_rd];
                    want_rd++;
                    if (got !== want) begin
                        fail_count++;
                        if (reported < 10) begin
                            reported++;
                            $display("response %0d: word %h/%h status %0d/%0d count %0d/%0d",
                                     answered, want.popped_word, got.popped_word,
                                     want.status, got.status, want.entry_count,
                                     got.entry_count);
                        end
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
design/deq_pkg.sv
design/deq_req_if.sv
design/deq_rsp_if.sv
design/deq_cell.sv
design/double_ended_queue_core.sv
dv/double_ended_queue_core_tb.sv
